// ----- hw/rtl/rtcu_pkg.sv -----
// shared types and constants for the route table cost update block
package rtcu_pkg;
    localparam int ROUTE_ENTRIES     = 64;
    localparam int NEIGHBOUR_ENTRIES = 16;
    localparam int RI_W = $clog2(ROUTE_ENTRIES);
    localparam int RC_W = $clog2(ROUTE_ENTRIES + 1);
    localparam int NI_W = (NEIGHBOUR_ENTRIES > 1) ? $clog2(NEIGHBOUR_ENTRIES) : 1;
    localparam int NC_W = $clog2(NEIGHBOUR_ENTRIES + 1);
    localparam logic [19:0] COST_UNREACHABLE = 20'd999999;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CHANGE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_LOCAL   = 3'd1;
    localparam logic [2:0] ST_FORWARD = 3'd2;
    localparam logic [2:0] ST_NONE    = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        logic [15:0] cost_value;
        logic [5:0]  entry_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] hop_address;
        logic [31:0] dest_address;
        logic [19:0] route_cost;
    } t_out;

    // one route entry as stored in a cell
    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] hop;
        logic        hop_valid;
        logic [19:0] metric;
    } t_route;

    // operation broadcast along the chain for one pass
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_SCAN   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_CHANGE = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] key;
        logic [RI_W-1:0] idx;
        t_route      wdata;
        logic [19:0] old_cost;
        logic [19:0] new_cost;
    } t_ctl;

    // token that moves one cell per cycle
    typedef struct packed {
        logic            found;
        logic [RI_W-1:0] idx;
        t_route          ent;
    } t_tok;
endpackage

// ----- hw/rtl/rtcu_cell.sv -----
// one routing table cell: holds an entry, compares it and passes the scan token on
module rtcu_cell
    import rtcu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [RI_W-1:0] i_pos,
    input  logic            i_live,
    input  t_ctl            i_ctl,
    input  t_tok            i_tok,
    output t_tok            o_tok
);
    t_route r_ent;
    t_route n_ent;
    t_tok   r_tok;
    t_tok   n_tok;
    logic signed [21:0] v;

    always_comb begin
        n_ent = r_ent;
        n_tok = i_tok;
        v = $signed({2'b0, r_ent.metric}) - $signed({2'b0, i_ctl.old_cost})
            + $signed({2'b0, i_ctl.new_cost});
        case (i_ctl.op)
            OP_SCAN: begin
                if (i_live && !i_tok.found && r_ent.dest == i_ctl.key) begin
                    n_tok.found = 1'b1;
                    n_tok.idx   = i_pos;
                    n_tok.ent   = r_ent;
                end
            end
            OP_READ: begin
                if (!i_tok.found && i_ctl.idx == i_pos) begin
                    n_tok.found = 1'b1;
                    n_tok.idx   = i_pos;
                    n_tok.ent   = r_ent;
                end
            end
            OP_WRITE: begin
                if (i_ctl.idx == i_pos) n_ent = i_ctl.wdata;
            end
            OP_CHANGE: begin
                if (i_live && i_ctl.idx == i_pos) begin
                    if (r_ent.hop_valid && r_ent.hop == i_ctl.key) begin
                        if (v < 0) n_ent.metric = '0;
                        else if (v > $signed({2'b0, COST_UNREACHABLE}))
                            n_ent.metric = COST_UNREACHABLE;
                        else n_ent.metric = v[19:0];
                    end else if (r_ent.dest == i_ctl.key
                                 && r_ent.metric > i_ctl.new_cost) begin
                        n_ent.hop       = i_ctl.key;
                        n_ent.hop_valid = 1'b1;
                        n_ent.metric    = i_ctl.new_cost;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) r_tok.found <= 1'b0;
        else r_tok.found <= n_tok.found;
        r_tok.idx <= n_tok.idx;
        r_tok.ent <= n_tok.ent;
    end

    assign o_tok = r_tok;
endmodule

// ----- hw/rtl/rtcu_nbr.sv -----
// neighbour table with a sequential search over its entries
module rtcu_nbr
    import rtcu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic            i_step,
    input  logic [31:0]     i_key,
    input  logic            i_wr,
    input  logic [NI_W-1:0] i_widx,
    input  logic [31:0]     i_waddr,
    input  logic [19:0]     i_wcost,
    input  logic [NC_W-1:0] i_count,
    output logic            o_found,
    output logic [NI_W-1:0] o_idx,
    output logic [19:0]     o_cost
);
    logic [31:0] r_addr [NEIGHBOUR_ENTRIES];
    logic [19:0] r_cost [NEIGHBOUR_ENTRIES];
    logic [NC_W-1:0] r_ptr;
    logic r_found;
    logic [NI_W-1:0] r_idx;
    logic hit;
    logic [NI_W-1:0] pidx;

    assign pidx = r_ptr[NI_W-1:0];
    assign hit = i_step && !r_found && (r_ptr < i_count)
                 && (r_addr[pidx] == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_ptr   <= '0;
            r_found <= 1'b0;
        end else if (i_step && r_ptr < i_count) begin
            r_ptr <= r_ptr + 1'b1;
            if (hit) r_found <= 1'b1;
        end
        if (hit) r_idx <= pidx;
        if (i_wr) begin
            r_addr[i_widx] <= i_waddr;
            r_cost[i_widx] <= i_wcost;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_cost  = r_cost[r_idx];
endmodule

// ----- hw/rtl/route_table_cost_update.sv -----
// top level: command sequencer over a chain of routing table cells
// One command is taken while busy is low; its result appears for one cycle on
// o_result with o_done. The receiver cannot stall results. Each route search holds
// the search on the chain of ROUTE_ENTRIES cells while a token moves one cell per
// cycle; a neighbour search steps over the stored neighbour entries; a cost change
// then updates one cell per cycle unless it is ignored. Lookup and read run one
// route search, a cost change one neighbour search, a link load touching this
// router one neighbour search and three route searches, any other link load two
// route searches and a self link none. The next command can be taken at the edge
// that takes the result. Configuration writes are taken at any time while idle.
module route_table_cost_update
    import rtcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_cmd,
    output logic        o_done,
    output t_out        o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_NSRCH = 6'b000010,
        S_RSRCH = 6'b000100,
        S_ACT   = 6'b001000,
        S_CHG   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_in    r_in;
    logic [31:0] r_own;
    logic [RC_W-1:0] r_rcnt;
    logic [NC_W-1:0] r_ncnt;
    logic [RC_W:0]   r_cnt;
    logic [2:0]      r_step;   // sub step of a load
    logic            r_ok;
    t_out            r_res;
    logic [31:0]     r_key;
    logic            r_done;
    logic [19:0]     r_old;

    t_ctl ctl;
    t_tok tok [ROUTE_ENTRIES+1];
    t_tok res_tok;
    logic nb_found;
    logic [NI_W-1:0] nb_idx;
    logic [19:0] nb_cost;
    logic nb_clr, nb_step, nb_wr;
    logic [NI_W-1:0] nb_widx;
    logic [19:0] nb_wcost;
    logic [31:0] nb_key;
    t_route rd_ent;
    logic [RI_W-1:0] r_cidx;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done = r_done;
    assign o_result = r_res;

    assign tok[0] = '0;
    genvar g;
    generate
        for (g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
            rtcu_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_pos(RI_W'(g)),
                .i_live(RC_W'(g) < r_rcnt),
                .i_ctl(ctl), .i_tok(tok[g]), .o_tok(tok[g+1])
            );
        end
    endgenerate
    assign res_tok = tok[ROUTE_ENTRIES];

    // the far end in a link that touches this router
    logic [31:0] far;
    logic touches;
    assign touches = (r_in.addr_a == r_own) || (r_in.addr_b == r_own);
    assign far = (r_in.addr_a == r_own) ? r_in.addr_b : r_in.addr_a;

    rtcu_nbr u_nbr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clr(nb_clr), .i_step(nb_step),
        .i_key(nb_key), .i_wr(nb_wr), .i_widx(nb_widx), .i_waddr(far),
        .i_wcost(nb_wcost), .i_count(r_ncnt),
        .o_found(nb_found), .o_idx(nb_idx), .o_cost(nb_cost)
    );
    assign nb_key = far;

    // load steps: 0 neighbour search, 1 direct route, 2 endpoint a, 3 endpoint b
    logic [31:0] ep;
    assign ep = (r_step == 3'd3) ? r_in.addr_b : (r_step == 3'd2) ? r_in.addr_a : far;

    always_comb begin
        ctl = '0;
        ctl.key = r_key;
        ctl.old_cost = r_old;
        ctl.new_cost = {4'b0, r_in.cost_value};
        nb_clr = 1'b0;
        nb_step = (r_state == S_NSRCH);
        nb_wr = 1'b0;
        nb_widx = nb_found ? nb_idx : r_ncnt[NI_W-1:0];
        nb_wcost = {4'b0, r_in.cost_value};
        rd_ent = res_tok.ent;
        if (r_state == S_IDLE) nb_clr = 1'b1;
        // lookups match on destination, reads on position
        if (r_state == S_RSRCH) begin
            if (r_in.cmd == CMD_READ) begin
                ctl.op  = OP_READ;
                ctl.idx = r_in.entry_index;
            end else ctl.op = OP_SCAN;
        end
        if (r_state == S_CHG) begin
            ctl.op = OP_CHANGE;
            ctl.idx = r_cidx;
        end
        if (r_state == S_ACT && r_in.cmd == CMD_LOAD) begin
            if (r_step == 3'd1) begin
                ctl.idx = res_tok.found ? res_tok.idx : r_rcnt[RI_W-1:0];
                ctl.wdata = '{dest: far, hop: far, hop_valid: 1'b1,
                              metric: {4'b0, r_in.cost_value}};
                if (res_tok.found || r_rcnt < RC_W'(ROUTE_ENTRIES)) ctl.op = OP_WRITE;
            end else if (r_step != 3'd0) begin
                ctl.idx = r_rcnt[RI_W-1:0];
                ctl.wdata = '{dest: ep, hop: '0, hop_valid: 1'b0,
                              metric: COST_UNREACHABLE};
                if (!(ep == r_own || res_tok.found || r_rcnt >= RC_W'(ROUTE_ENTRIES)))
                    ctl.op = OP_WRITE;
            end
        end
        if (r_state == S_ACT && r_in.cmd == CMD_CHANGE && touches && nb_found)
            nb_wr = 1'b1;
        if (r_state == S_ACT && r_in.cmd == CMD_LOAD && r_step == 3'd0
            && (nb_found || r_ncnt < NC_W'(NEIGHBOUR_ENTRIES)))
            nb_wr = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_own   <= '0;
            r_rcnt  <= '0;
            r_ncnt  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_OUT);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) r_own <= i_cfg_data;
                    if (start) begin
                        r_in  <= i_cmd;
                        r_ok  <= 1'b1;
                        r_cnt <= '0;
                        r_res <= '0;
                        if (i_cmd.cmd == CMD_LOAD) begin
                            if (i_cmd.addr_a == r_own && i_cmd.addr_b == r_own)
                                r_state <= S_OUT;
                            else if ((i_cmd.addr_a == r_own) || (i_cmd.addr_b == r_own)) begin
                                r_step  <= 3'd0;
                                r_state <= S_NSRCH;
                            end else begin
                                r_step  <= 3'd2;
                                r_key   <= i_cmd.addr_a;
                                r_state <= S_RSRCH;
                            end
                        end else if (i_cmd.cmd == CMD_CHANGE) begin
                            r_state <= S_NSRCH;
                        end else begin
                            r_key   <= i_cmd.addr_b;
                            r_state <= S_RSRCH;
                        end
                    end
                end
                S_NSRCH: begin
                    if (r_cnt == (RC_W+1)'(NEIGHBOUR_ENTRIES)) begin
                        r_cnt <= '0;
                        r_state <= S_ACT;
                    end else r_cnt <= r_cnt + 1'b1;
                end
                S_RSRCH: begin
                    if (r_cnt == (RC_W+1)'(ROUTE_ENTRIES)) begin
                        r_cnt <= '0;
                        r_state <= S_ACT;
                    end else r_cnt <= r_cnt + 1'b1;
                end
                S_ACT: begin
                    case (r_in.cmd)
                        CMD_LOAD: begin
                            if (r_step == 3'd0) begin
                                if (!nb_found) begin
                                    if (r_ncnt < NC_W'(NEIGHBOUR_ENTRIES))
                                        r_ncnt <= r_ncnt + 1'b1;
                                    else r_ok <= 1'b0;
                                end
                                r_step <= 3'd1; r_key <= far; r_state <= S_RSRCH;
                            end else if (r_step == 3'd1) begin
                                if (!res_tok.found) begin
                                    if (r_rcnt < RC_W'(ROUTE_ENTRIES))
                                        r_rcnt <= r_rcnt + 1'b1;
                                    else r_ok <= 1'b0;
                                end
                                r_step <= 3'd2; r_key <= r_in.addr_a; r_state <= S_RSRCH;
                            end else begin
                                if (ep != r_own && !res_tok.found) begin
                                    if (r_rcnt < RC_W'(ROUTE_ENTRIES))
                                        r_rcnt <= r_rcnt + 1'b1;
                                    else r_ok <= 1'b0;
                                end
                                if (r_step == 3'd2) begin
                                    r_step <= 3'd3; r_key <= r_in.addr_b;
                                    r_state <= S_RSRCH;
                                end else begin
                                    r_res.status <= (ep != r_own && !res_tok.found
                                        && r_rcnt >= RC_W'(ROUTE_ENTRIES)) || !r_ok
                                        ? ST_FULL : ST_DONE;
                                    r_state <= S_OUT;
                                end
                            end
                        end
                        CMD_LOOKUP: begin
                            r_res.dest_address <= r_in.addr_b;
                            if (r_in.addr_b == r_own) r_res.status <= ST_LOCAL;
                            else if (res_tok.found && rd_ent.hop_valid) begin
                                r_res.status      <= ST_FORWARD;
                                r_res.hop_address <= rd_ent.hop;
                                r_res.route_cost  <= rd_ent.metric;
                            end else begin
                                r_res.status     <= ST_NONE;
                                r_res.route_cost <= COST_UNREACHABLE;
                            end
                            r_state <= S_OUT;
                        end
                        CMD_CHANGE: begin
                            if (!touches || !nb_found) begin
                                r_res.status <= ST_NONE;
                                r_state <= S_OUT;
                            end else begin
                                r_key   <= far;
                                r_cidx  <= '0;
                                r_old   <= nb_cost;
                                r_state <= S_CHG;
                            end
                        end
                        default: begin
                            if (RC_W'(r_in.entry_index) < r_rcnt) begin
                                r_res.status <= ST_DONE;
                                r_res.dest_address <= rd_ent.dest;
                                r_res.hop_address  <= rd_ent.hop_valid ? rd_ent.hop : '0;
                                r_res.route_cost   <= rd_ent.metric;
                            end else r_res.status <= ST_NONE;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_CHG: begin
                    // old neighbour cost sits in r_old, the store already has the new one
                    r_cidx <= r_cidx + 1'b1;
                    if (r_cidx == RI_W'(ROUTE_ENTRIES-1)) begin
                        r_res.status <= ST_DONE;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_done_one;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done;
    endproperty
    a_done_one: assert property (p_done_one) else $error("double done");

    property p_idle_after;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |-> !busy;
    endproperty
    a_idle_after: assert property (p_idle_after) else $error("busy at done");

    property p_cnt;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_rcnt <= RC_W'(ROUTE_ENTRIES)) && (r_ncnt <= NC_W'(NEIGHBOUR_ENTRIES));
    endproperty
    a_cnt: assert property (p_cnt) else $error("count overflow");
endmodule

// ----- dv/route_table_cost_update_tb.sv -----
// testbench for the routing table block: directed and random commands against a local predictor
module route_table_cost_update_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtcu_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_cmd;
    logic        o_done;
    t_out        o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    route_table_cost_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_done(o_done), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [31:0] own_addr;
    logic [31:0] rt_dest [ROUTE_ENTRIES];
    logic [31:0] rt_hop [ROUTE_ENTRIES];
    logic        rt_hop_ok [ROUTE_ENTRIES];
    logic [19:0] rt_cost [ROUTE_ENTRIES];
    int          rt_count;
    logic [31:0] nb_addr [NEIGHBOUR_ENTRIES];
    logic [19:0] nb_cost [NEIGHBOUR_ENTRIES];
    int          nb_count;

    t_out  expected_results[$];
    int    mismatches;
    int    cycles;
    int    send_gap_pct;
    // pool of addresses so that lookups and changes hit stored routes
    logic [31:0] addr_pool[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int find_route(logic [31:0] d);
        for (int i = 0; i < rt_count; i++) if (rt_dest[i] == d) return i;
        return -1;
    endfunction

    function automatic int find_nb(logic [31:0] d);
        for (int i = 0; i < nb_count; i++) if (nb_addr[i] == d) return i;
        return -1;
    endfunction

    function automatic bit add_dest(logic [31:0] d);
        if (d == own_addr || find_route(d) >= 0) return 1;
        if (rt_count >= ROUTE_ENTRIES) return 0;
        rt_dest[rt_count] = d;
        rt_hop[rt_count] = '0;
        rt_hop_ok[rt_count] = 1'b0;
        rt_cost[rt_count] = COST_UNREACHABLE;
        rt_count++;
        return 1;
    endfunction

    function automatic bit add_direct(logic [31:0] nb, logic [19:0] c);
        bit ok = 1;
        int n = find_nb(nb);
        int r = find_route(nb);
        if (n >= 0) nb_cost[n] = c;
        else if (nb_count < NEIGHBOUR_ENTRIES) begin
            nb_addr[nb_count] = nb;
            nb_cost[nb_count] = c;
            nb_count++;
        end else ok = 0;
        if (r < 0 && rt_count < ROUTE_ENTRIES) begin
            r = rt_count;
            rt_dest[r] = nb;
            rt_count++;
        end
        if (r >= 0) begin
            rt_hop[r] = nb;
            rt_hop_ok[r] = 1'b1;
            rt_cost[r] = c;
        end else ok = 0;
        return ok;
    endfunction

    function automatic t_out predict_route_result(t_in c);
        t_out o = '0;
        bit ok = 1;
        int n = -1;
        int r;
        logic [31:0] nb = '0;
        longint v, old;
        case (c.cmd)
            CMD_LOAD: begin
                if (!(c.addr_a == own_addr && c.addr_b == own_addr)) begin
                    if (c.addr_a == own_addr) ok = add_direct(c.addr_b, 20'(c.cost_value)) && ok;
                    else if (c.addr_b == own_addr)
                        ok = add_direct(c.addr_a, 20'(c.cost_value)) && ok;
                    ok = add_dest(c.addr_a) && ok;
                    ok = add_dest(c.addr_b) && ok;
                end
                o.status = ok ? ST_DONE : ST_FULL;
            end
            CMD_LOOKUP: begin
                o.dest_address = c.addr_b;
                if (c.addr_b == own_addr) o.status = ST_LOCAL;
                else begin
                    r = find_route(c.addr_b);
                    if (r >= 0 && rt_hop_ok[r]) begin
                        o.status = ST_FORWARD;
                        o.hop_address = rt_hop[r];
                        o.route_cost = rt_cost[r];
                    end else begin
                        o.status = ST_NONE;
                        o.route_cost = COST_UNREACHABLE;
                    end
                end
            end
            CMD_CHANGE: begin
                if (c.addr_a == own_addr) begin
                    nb = c.addr_b;
                    n = find_nb(nb);
                end else if (c.addr_b == own_addr) begin
                    nb = c.addr_a;
                    n = find_nb(nb);
                end
                if (n < 0) o.status = ST_NONE;
                else begin
                    old = nb_cost[n];
                    nb_cost[n] = 20'(c.cost_value);
                    for (int i = 0; i < rt_count; i++) begin
                        if (rt_hop_ok[i] && rt_hop[i] == nb) begin
                            v = longint'(rt_cost[i]) - old + longint'(c.cost_value);
                            if (v < 0) v = 0;
                            if (v > 999999) v = 999999;
                            rt_cost[i] = 20'(v);
                        end else if (rt_dest[i] == nb && rt_cost[i] > 20'(c.cost_value)) begin
                            rt_hop[i] = nb;
                            rt_hop_ok[i] = 1'b1;
                            rt_cost[i] = 20'(c.cost_value);
                        end
                    end
                    o.status = ST_DONE;
                end
            end
            default: begin
                if (int'(c.entry_index) < rt_count) begin
                    o.status = ST_DONE;
                    o.dest_address = rt_dest[c.entry_index];
                    o.hop_address = rt_hop_ok[c.entry_index] ? rt_hop[c.entry_index] : '0;
                    o.route_cost = rt_cost[c.entry_index];
                end else o.status = ST_NONE;
            end
        endcase
        return o;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_result);
            end else begin
                e = expected_results.pop_front();
                if (o_result !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", e, o_result);
                end
            end
        end
    end

    task automatic send_cmd(t_in c);
        while ($urandom_range(99) < send_gap_pct) begin
            start <= 1'b0;
            i_cmd <= make_cmd(2'($urandom), $urandom, $urandom, 16'($urandom), 6'($urandom));
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        expected_results.insert(expected_results.size(), predict_route_result(c));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_own_address(logic [31:0] a);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= a;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
        own_addr = a;
    endtask

    function automatic t_in make_cmd(logic [1:0] op, logic [31:0] a, logic [31:0] b,
                                     logic [15:0] cv, logic [5:0] ix);
        t_in c;
        c.cmd = op;
        c.addr_a = a;
        c.addr_b = b;
        c.cost_value = cv;
        c.entry_index = ix;
        return c;
    endfunction

    function automatic logic [31:0] pick_addr();
        int k = $urandom_range(9);
        if (k < 3) return own_addr;
        if (k < 8 && addr_pool.size() > 0) return addr_pool[$urandom_range(addr_pool.size() - 1)];
        return $urandom;
    endfunction

    task automatic test_directed();
        send_cmd(make_cmd(CMD_READ, 0, 0, '0, 6'd0));
        send_cmd(make_cmd(CMD_LOOKUP, 0, 32'hffff_ffff, '0, '0));
        send_cmd(make_cmd(CMD_LOOKUP, 0, own_addr, '0, '0));
        send_cmd(make_cmd(CMD_LOAD, own_addr, own_addr, 16'd5, '0));
        send_cmd(make_cmd(CMD_LOAD, own_addr, 32'hffff_ffff, 16'hffff, '0));
        send_cmd(make_cmd(CMD_LOAD, 32'h0a00_0002, own_addr, 16'd0, '0));
        send_cmd(make_cmd(CMD_LOAD, 32'h0a00_0002, 32'h0a00_0003, 16'd7, '0));
        send_cmd(make_cmd(CMD_LOAD, own_addr, 32'h0a00_0002, 16'd40, '0));
        send_cmd(make_cmd(CMD_LOOKUP, 0, 32'h0a00_0003, '0, '0));
        send_cmd(make_cmd(CMD_LOOKUP, 0, 32'h0a00_0002, '0, '0));
        send_cmd(make_cmd(CMD_CHANGE, own_addr, 32'h0a00_0002, 16'd3, '0));
        send_cmd(make_cmd(CMD_CHANGE, 32'hffff_ffff, own_addr, 16'd0, '0));
        send_cmd(make_cmd(CMD_CHANGE, own_addr, 32'h1234_5678, 16'd9, '0));
        send_cmd(make_cmd(CMD_CHANGE, 32'h0a00_0002, 32'h0a00_0003, 16'd9, '0));
        send_cmd(make_cmd(CMD_READ, 0, 0, '0, 6'd1));
        send_cmd(make_cmd(CMD_READ, 0, 0, '0, 6'd2));
        send_cmd(make_cmd(CMD_READ, 0, 0, '0, 6'd63));
    endtask

    // fill both tables past capacity to reach the full status
    task automatic test_table_full();
        for (int i = 0; i < 40; i++)
            send_cmd(make_cmd(CMD_LOAD, own_addr, 32'h0b00_0000 + i, 16'($urandom), '0));
        for (int i = 0; i < 20; i++) send_cmd(make_cmd(CMD_READ, 0, 0, '0, 6'(44 + i)));
        send_cmd(make_cmd(CMD_LOAD, 32'h0c00_0001, 32'h0c00_0002, '0, '0));
        send_cmd(make_cmd(CMD_LOOKUP, 0, 32'h0b00_0020, '0, '0));
    endtask

    task automatic test_random(int count);
        logic [1:0] op;
        for (int i = 0; i < count; i++) begin
            op = 2'($urandom_range(3));
            if (op == CMD_LOAD && $urandom_range(3) != 0)
                addr_pool.insert(addr_pool.size(), $urandom);
            send_cmd(make_cmd(op, pick_addr(), pick_addr(), 16'($urandom), 6'($urandom)));
        end
    endtask

    task automatic reset_tables();
        rt_count = 0;
        nb_count = 0;
        addr_pool.delete();
    endtask

    initial begin
        cycles = 0;
        mismatches = 0;
        send_gap_pct = 6;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        own_addr = '0;
        reset_tables();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_own_address(32'hc0a8_0001);
        test_directed();
        test_random(350);
        send_gap_pct = 58;
        write_own_address(32'hffff_ffff);
        test_random(400);
        test_table_full();
        send_gap_pct = 0;
        write_own_address(32'h0000_0000);
        test_random(500);

        drain_results();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- route_table_cost_update.f -----
hw/rtl/rtcu_pkg.sv
hw/rtl/rtcu_cell.sv
hw/rtl/rtcu_nbr.sv
hw/rtl/route_table_cost_update.sv
dv/route_table_cost_update_tb.sv
